// ----- hw/rtl/rsde_pkg.sv -----
// Shared types and constants of the postfix evaluator: character classes,
// operator and status codes, and the controller/datapath command and status structs.
// No dependencies.
package rsde_pkg;

  localparam int unsigned BAL_BITS = 17;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [1:0] {
    CC_SKIP,
    CC_DIGIT,
    CC_OP,
    CC_BAD
  } char_class_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_INVALID  = 3'd2,
    ST_DIV_ZERO = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic latch;        // capture the incoming character
    logic mark_bad;
    logic push;         // digit
    logic op_begin;     // operator bookkeeping and underflow check
    logic rd_operands;  // read top two stack entries
    logic alu_write;    // add/sub result to stack
    logic div_zero;
    logic start_iter;   // load shift-add / restoring-divide unit
    logic step;
    logic iter_write;
    logic rd_base;      // read bottom entry for the result
    logic emit;         // load output register, clear expression state
  } rsde_cmd_t;

  typedef struct packed {
    char_class_e cls;
    op_e         op;
    logic        last;
    logic        err_set;
    logic        lt2;
    logic        full;
    logic        r_zero;
    logic        iter_done;
    logic        out_free;
  } rsde_sts_t;

  function automatic char_class_e classify(logic [7:0] c);
    char_class_e cls;
    if (c == CHAR_SPACE || c == CHAR_TAB) begin
      cls = CC_SKIP;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      cls = CC_DIGIT;
    end else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH) begin
      cls = CC_OP;
    end else begin
      cls = CC_BAD;
    end
    return cls;
  endfunction

  function automatic op_e decode_op(logic [7:0] c);
    op_e op;
    if (c == CHAR_MINUS) begin
      op = OP_SUB;
    end else if (c == CHAR_STAR) begin
      op = OP_MUL;
    end else if (c == CHAR_SLASH) begin
      op = OP_DIV;
    end else begin
      op = OP_ADD;
    end
    return op;
  endfunction

endpackage

// ----- hw/rtl/rsde_if.sv -----
// Valid/ready channel interfaces of the postfix evaluator: character input
// and result output. No dependencies.
interface rsde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface rsde_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ----- hw/rtl/rsde_ctrl.sv -----
// Sequencing FSM of the postfix evaluator: steps each character through
// decode, operand read, arithmetic and result. Depends on rsde_pkg.
module rsde_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rsde_pkg::rsde_sts_t sts_i,
  output rsde_pkg::rsde_cmd_t cmd_o
);
  import rsde_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_OPRD = 7'b0000100,
    S_ITER = 7'b0001000,
    S_WB   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_RES  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  state_e after_char;

  assign in_ready_o = (state_q == S_IDLE);
  assign after_char = sts_i.last ? S_FIN : S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = after_char;
        case (sts_i.cls)
          CC_DIGIT: cmd_o.push = 1'b1;
          CC_BAD:   cmd_o.mark_bad = 1'b1;
          CC_OP: begin
            cmd_o.op_begin = 1'b1;
            if (!sts_i.err_set && !sts_i.lt2) begin
              cmd_o.rd_operands = 1'b1;
              state_d           = S_OPRD;
            end
          end
          default: ;
        endcase
      end
      S_OPRD: begin
        state_d = after_char;
        case (sts_i.op)
          OP_ADD, OP_SUB: cmd_o.alu_write = 1'b1;
          OP_MUL: begin
            cmd_o.start_iter = 1'b1;
            state_d          = S_ITER;
          end
          default: begin
            if (sts_i.r_zero) begin
              cmd_o.div_zero = 1'b1;
            end else begin
              cmd_o.start_iter = 1'b1;
              state_d          = S_ITER;
            end
          end
        endcase
      end
      S_ITER: begin
        cmd_o.step = 1'b1;
        if (sts_i.iter_done) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.iter_write = 1'b1;
        state_d          = after_char;
      end
      S_FIN: begin
        cmd_o.rd_base = 1'b1;
        state_d       = S_RES;
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/rsde_dp.sv -----
// Datapath of the postfix evaluator: operand stack memory, expression
// bookkeeping, shared bit-serial multiply/divide unit and output register.
// Depends on rsde_pkg.
module rsde_dp #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_char_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  out_value_o,
  output logic [2:0]          out_status_o,
  input  rsde_pkg::rsde_cmd_t cmd_i,
  output rsde_pkg::rsde_sts_t sts_o
);
  import rsde_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned IW = $clog2(VALUE_BITS);

  logic [VB-1:0] stack_mem [STACK_DEPTH];

  logic [7:0]          char_q;
  logic                last_q;
  logic [CW-1:0]       count_q, count_d;
  logic [BAL_BITS-1:0] bal_q, bal_d;
  logic                seen_q, seen_d;
  logic                bad_q, bad_d;
  status_e             err_q, err_d;

  logic [VB-1:0] r_q, l_q;
  logic [VB-1:0] work_a_q, work_a_d, work_b_q, work_b_d, work_c_q, work_c_d;
  logic          neg_q, is_div_q;
  logic [IW-1:0] it_cnt_q;

  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic [2:0]         out_status_q;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic          full, lt2;
  op_e           op;
  logic [3:0]    digit;
  logic [VB-1:0] alu_res, iter_raw, iter_res, mag_l, mag_r;
  logic [VB:0]   trial;
  logic          mem_we;
  logic [AW-1:0] wr_addr, ra0, ra1;
  logic [VB-1:0] wr_data;
  status_e       res_status;
  logic [63:0]   top_ext;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);
  assign full   = (count_q >= CW'(STACK_DEPTH));
  assign lt2    = (count_q < CW'(2));
  assign op     = decode_op(char_q);
  assign digit  = 4'(char_q - CHAR_ZERO);

  assign alu_res = (op == OP_SUB) ? (l_q - r_q) : (l_q + r_q);
  assign mag_l   = l_q[VB-1] ? (VB'(0) - l_q) : l_q;
  assign mag_r   = r_q[VB-1] ? (VB'(0) - r_q) : r_q;
  assign trial   = {work_a_q, work_b_q[VB-1]} - {1'b0, work_c_q};
  assign iter_raw = is_div_q ? work_b_q : work_a_q;
  assign iter_res = neg_q ? (VB'(0) - iter_raw) : iter_raw;

  assign sts_o.cls       = classify(char_q);
  assign sts_o.op        = op;
  assign sts_o.last      = last_q;
  assign sts_o.err_set   = (err_q != ST_OK);
  assign sts_o.lt2       = lt2;
  assign sts_o.full      = full;
  assign sts_o.r_zero    = (r_q == '0);
  assign sts_o.iter_done = (it_cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Stack memory: one write port, two registered read ports
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cnt_m2[AW-1:0];
    wr_data = alu_res;
    if (cmd_i.push && err_q == ST_OK && !full) begin
      mem_we  = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_data = VB'(digit);
    end else if (cmd_i.alu_write) begin
      mem_we = 1'b1;
    end else if (cmd_i.iter_write) begin
      mem_we  = 1'b1;
      wr_data = iter_res;
    end
  end

  assign ra0 = cmd_i.rd_base ? '0 : cnt_m1[AW-1:0];
  assign ra1 = cnt_m2[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_operands || cmd_i.rd_base) begin
      r_q <= stack_mem[ra0];
      l_q <= stack_mem[ra1];
    end
  end

  // Expression bookkeeping; the first stack error sticks
  always_comb begin
    count_d = count_q;
    bal_d   = bal_q;
    seen_d  = seen_q;
    bad_d   = bad_q;
    err_d   = err_q;
    if (cmd_i.emit) begin
      count_d = '0;
      bal_d   = '0;
      seen_d  = 1'b0;
      bad_d   = 1'b0;
      err_d   = ST_OK;
    end else begin
      if (cmd_i.mark_bad) bad_d = 1'b1;
      if (cmd_i.push) begin
        bal_d = bal_q + BAL_BITS'(1);
        if (err_q == ST_OK) begin
          if (full) err_d = ST_OVERFLOW;
          else      count_d = count_q + CW'(1);
        end
      end
      if (cmd_i.op_begin) begin
        bal_d  = bal_q - BAL_BITS'(1);
        seen_d = 1'b1;
        if (err_q == ST_OK && lt2) err_d = ST_INVALID;
      end
      if (cmd_i.div_zero) err_d = ST_DIV_ZERO;
      if (cmd_i.alu_write || cmd_i.iter_write) count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bal_q   <= '0;
      seen_q  <= 1'b0;
      bad_q   <= 1'b0;
      err_q   <= ST_OK;
    end else begin
      count_q <= count_d;
      bal_q   <= bal_d;
      seen_q  <= seen_d;
      bad_q   <= bad_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
  end

  // Shared unit: shift-add multiply (a = product, b = multiplicand, c = multiplier)
  // or restoring divide on magnitudes (a = remainder, b = quotient, c = divisor)
  always_comb begin
    work_a_d = work_a_q;
    work_b_d = work_b_q;
    work_c_d = work_c_q;
    if (cmd_i.start_iter) begin
      work_a_d = '0;
      work_b_d = (op == OP_DIV) ? mag_l : l_q;
      work_c_d = (op == OP_DIV) ? mag_r : r_q;
    end else if (cmd_i.step) begin
      if (is_div_q) begin
        if (!trial[VB]) begin
          work_a_d = trial[VB-1:0];
          work_b_d = {work_b_q[VB-2:0], 1'b1};
        end else begin
          work_a_d = {work_a_q[VB-2:0], work_b_q[VB-1]};
          work_b_d = {work_b_q[VB-2:0], 1'b0};
        end
      end else begin
        if (work_c_q[0]) work_a_d = work_a_q + work_b_q;
        work_b_d = {work_b_q[VB-2:0], 1'b0};
        work_c_d = {1'b0, work_c_q[VB-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_a_q <= work_a_d;
    work_b_q <= work_b_d;
    work_c_q <= work_c_d;
    if (cmd_i.start_iter) begin
      is_div_q <= (op == OP_DIV);
      neg_q    <= (op == OP_DIV) && (l_q[VB-1] ^ r_q[VB-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_cnt_q <= '0;
    end else if (cmd_i.start_iter) begin
      it_cnt_q <= IW'(VALUE_BITS - 1);
    end else if (cmd_i.step && it_cnt_q != '0) begin
      it_cnt_q <= it_cnt_q - IW'(1);
    end
  end

  // Result status by precedence
  always_comb begin
    if (bad_q) begin
      res_status = ST_BAD_CHAR;
    end else if (bal_q != BAL_BITS'(1) || !seen_q) begin
      res_status = ST_INVALID;
    end else if (err_q != ST_OK) begin
      res_status = err_q;
    end else if (count_q != CW'(1)) begin
      res_status = ST_INVALID;
    end else begin
      res_status = ST_OK;
    end
  end

  assign top_ext = 64'($signed(r_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status;
      out_value_q  <= (res_status == ST_OK) ? top_ext[31:0] : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

// ----- hw/rtl/rpn_single_digit_evaluator_unit.sv -----
// Postfix expression evaluator, top level: joins the sequencing FSM and the
// datapath to the channel interfaces. Depends on rsde_pkg, rsde_if,
// rsde_ctrl and rsde_dp.
//
// Usage: characters arrive on in_ch (char_code, last_char), one per transfer.
// Space and tab are skipped, digits push 0..9, + - * / combine the top two
// entries. The character flagged last_char yields one transfer on out_ch
// carrying the stack top (value) and status; all other characters yield none.
//
// Steps per character, from input transfer to next ready:
//   space, tab, digit, bad character, operator on an error or underflow: decode
//   + and - : decode, operand read and write of the sum or difference
//   * and / : decode, operand read, then, unless dividing by zero, the shared
//             unit, one multiplier or quotient bit per cycle, and write-back
//   last character: then the bottom-entry read and the output load.
// One character is in work at a time; in_ch.ready is high only between items.
// The result sits in an output register: the next expression may start
// while it waits. If out_ch is stalled when a second result is ready, the
// block holds that result and takes no input until the register frees.
// Reset clears the stack count and all expression state; the stack memory
// is not cleared and needs no pass after reset.
module rpn_single_digit_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsde_in_if.sink           in_ch,
  rsde_out_if.source        out_ch
);
  import rsde_pkg::*;

  rsde_cmd_t cmd;
  rsde_sts_t sts;

  rsde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsde_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_char_i    (in_ch.char_code),
    .in_last_i    (in_ch.last_char),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_value_o  (out_ch.value),
    .out_status_o (out_ch.status),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // one character in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a character is in work");

  a_count_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.full && sts.lt2))
    else $error("stack count inconsistent");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_ch.valid)
    else $error("result load did not raise output valid");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |-> !cmd.emit)
    else $error("result overwrote a pending output");

endmodule
